### rtl/tcbe_pkg.sv
// tcbe_pkg: shared types and constants for the tlsf class bitmap engine
// used by tcbe_class_map, tcbe_fit_search and tlsf_class_bitmap_engine
// no dependencies
package tcbe_pkg;

    // field widths fixed by the item format
    localparam int SIZE_W     = 24;
    localparam int N_W        = 25;
    localparam int FL_W       = 5;
    localparam int SL_W       = 3;
    localparam int CLS_W      = FL_W + SL_W;
    localparam int TOTAL_W    = 32;
    localparam int SL_CLASSES = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_EMPTY    = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    // size to class mapping
    typedef struct packed {
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
        logic [FL_W-1:0] top;
    } t_cls_map;

    // result of the fit search
    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] cls;
    } t_fit_res;

endpackage

### rtl/tcbe_class_map.sv
// tcbe_class_map: maps a size in words to its first/second level class
// depends on tcbe_pkg
module tcbe_class_map (
    input  logic [tcbe_pkg::N_W-1:0] i_n,
    output tcbe_pkg::t_cls_map       o_map
);

    localparam int NW = tcbe_pkg::N_W;
    localparam int FW = tcbe_pkg::FL_W;
    localparam int SW = tcbe_pkg::SL_W;

    logic [FW-1:0] top;
    logic [NW-1:0] shifted;

    // index of the highest set bit
    always_comb begin
        top = '0;
        for (int k = 0; k < NW; k++) begin
            if (i_n[k]) begin
                top = FW'(k);
            end
        end
    end

    // small sizes map straight into class zero
    always_comb begin
        shifted   = i_n >> (top - FW'(3));
        o_map.top = top;
        if (i_n < NW'(8)) begin
            o_map.fl = '0;
            o_map.sl = i_n[SW-1:0];
        end else begin
            o_map.fl = top - FW'(2);
            o_map.sl = shifted[SW-1:0];
        end
    end

endmodule

### rtl/tcbe_fit_search.sv
// tcbe_fit_search: lowest occupied class at or above a start class
// depends on tcbe_pkg
module tcbe_fit_search #(
    parameter int NCLS = 176,
    parameter int IDXW = 8
) (
    input  logic [NCLS-1:0]            i_occ,
    input  logic [tcbe_pkg::CLS_W-1:0] i_start,
    output tcbe_pkg::t_fit_res         o_res
);

    localparam int CW = tcbe_pkg::CLS_W;

    logic [NCLS-1:0] masked;
    logic [IDXW-1:0] idx;

    // keep only occupied classes at or above the start class
    always_comb begin
        for (int k = 0; k < NCLS; k++) begin
            masked[k] = i_occ[k] && (CW'(k) >= i_start);
        end
    end

    // priority encode the lowest one
    always_comb begin
        idx = '0;
        for (int k = NCLS - 1; k >= 0; k--) begin
            if (masked[k]) begin
                idx = IDXW'(k);
            end
        end
        o_res.found = |masked;
        o_res.cls   = CW'(idx);
    end

endmodule

### rtl/tlsf_class_bitmap_engine.sv
// tlsf_class_bitmap_engine: top level of the two-level segregated fit index
// depends on tcbe_pkg, tcbe_class_map, tcbe_fit_search
//
// usage
// - a command beat is taken on a rising edge with start high and busy low;
//   busy stays low, so a new command can be issued every cycle
// - opcode insert counts a free block into the class of size_words, remove
//   takes it out again, search rounds the size up to its class and reports
//   the lowest non-empty class that fits
// - exactly one result beat per command, flagged by o_done for one cycle;
//   each command passes through the input register, then the result register,
//   and o_done is registered together with the result fields,
//   one result per cycle at full rate
// - per-class counts live in a one-write one-read memory read in the accept
//   cycle; a write to the same class by the command just ahead is forwarded
// - the receiver cannot stall: results are not held, so it must take o_done
//   beats as they come
// - reset (synchronous, active low) empties all classes and clears the
//   totals at once through per-class valid bits; no clearing pass is needed
// - free totals saturate; remove from an empty class and insert into a full
//   class are reported in o_error_code and leave the state unchanged
module tlsf_class_bitmap_engine #(
    parameter int SIZE_BITS  = 24,
    parameter int FL_CLASSES = 22,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [tcbe_pkg::SIZE_W-1:0]   i_size_words,
    output logic                          o_done,
    output logic                          o_found,
    output logic [tcbe_pkg::FL_W-1:0]     o_first_level,
    output logic [tcbe_pkg::SL_W-1:0]     o_second_level,
    output logic [tcbe_pkg::N_W-1:0]      o_rounded_words,
    output logic [1:0]                    o_error_code,
    output logic [tcbe_pkg::TOTAL_W-1:0]  o_free_block_total,
    output logic [tcbe_pkg::TOTAL_W-1:0]  o_free_word_total
);

    localparam int SizeW = tcbe_pkg::SIZE_W;
    localparam int NW    = tcbe_pkg::N_W;
    localparam int FW    = tcbe_pkg::FL_W;
    localparam int SW    = tcbe_pkg::SL_W;
    localparam int CW    = tcbe_pkg::CLS_W;
    localparam int TW    = tcbe_pkg::TOTAL_W;
    localparam int NCLS  = FL_CLASSES * tcbe_pkg::SL_CLASSES;
    localparam int IDXW  = $clog2(NCLS);
    localparam logic [SizeW-1:0] SizeMask = (SIZE_BITS >= SizeW) ? {SizeW{1'b1}} :
                                            SizeW'((64'd1 << SIZE_BITS) - 64'd1);

    // input stage signals
    logic                 accept;
    logic [SizeW-1:0]     in_n;
    tcbe_pkg::t_cls_map   in_map;
    logic [FW-1:0]        in_cfl;
    logic [SW-1:0]        in_csl;
    logic [IDXW-1:0]      in_idx;
    logic [NW-1:0]        in_gmask;
    logic [NW-1:0]        in_rounded;

    // input stage registers
    logic                 r_s1_vld;
    tcbe_pkg::t_op        r_op;
    logic [SizeW-1:0]     r_n;
    logic [FW-1:0]        r_fl;
    logic [SW-1:0]        r_sl;
    logic [FW-1:0]        r_cfl;
    logic [SW-1:0]        r_csl;
    logic [IDXW-1:0]      r_idx;
    logic [NW-1:0]        r_rounded;
    logic                 r_fwd;
    logic [COUNT_BITS-1:0] r_fwd_cnt;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                 r_rd_vld;

    // class state
    logic [COUNT_BITS-1:0] mem_cnt [NCLS];
    logic [NCLS-1:0]      r_vld;
    logic [NCLS-1:0]      r_occ;
    logic [NCLS-1:0]      n_occ;
    logic [TW-1:0]        r_fw;
    logic [TW-1:0]        n_fw;
    logic [TW-1:0]        r_fb;
    logic [TW-1:0]        n_fb;

    // update stage signals
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                 wr_en;
    logic [TW:0]          fw_sum;
    tcbe_pkg::t_err       err;
    tcbe_pkg::t_cls_map   rnd_map;
    tcbe_pkg::t_fit_res   fit;
    logic                 in_range;

    // result registers
    logic                 r_done;
    logic                 r_found;
    logic                 n_found;
    logic [FW-1:0]        r_out_fl;
    logic [FW-1:0]        n_out_fl;
    logic [SW-1:0]        r_out_sl;
    logic [SW-1:0]        n_out_sl;
    logic [NW-1:0]        r_out_rnd;
    logic [NW-1:0]        n_out_rnd;
    tcbe_pkg::t_err       r_err;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign in_n   = i_size_words & SizeMask;

    // map the incoming size, clamp to the top class for count access
    tcbe_class_map u_in_map (
        .i_n   (NW'(in_n)),
        .o_map (in_map)
    );

    always_comb begin
        if (in_map.fl >= FW'(FL_CLASSES)) begin
            in_cfl = FW'(FL_CLASSES - 1);
            in_csl = SW'(tcbe_pkg::SL_CLASSES - 1);
        end else begin
            in_cfl = in_map.fl;
            in_csl = in_map.sl;
        end
        in_idx = IDXW'({in_cfl, in_csl});
    end

    // round the size up to its class granule
    always_comb begin
        in_gmask = (NW'(1) << (in_map.top - FW'(3))) - NW'(1);
        if (NW'(in_n) < NW'(8)) begin
            in_rounded = NW'(in_n);
        end else begin
            in_rounded = (NW'(in_n) + in_gmask) & ~in_gmask;
        end
    end

    // input register and count read, with forwarding from the update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_fwd    <= wr_en && (r_idx == in_idx);
        end
        r_op      <= tcbe_pkg::t_op'(i_opcode);
        r_n       <= in_n;
        r_fl      <= in_map.fl;
        r_sl      <= in_map.sl;
        r_cfl     <= in_cfl;
        r_csl     <= in_csl;
        r_idx     <= in_idx;
        r_rounded <= in_rounded;
        r_fwd_cnt <= n_cnt;
    end

    // class count memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_cnt[r_idx] <= n_cnt;
        end
        r_rd_cnt <= mem_cnt[in_idx];
    end

    // count update and totals
    always_comb begin
        cnt_cur = r_fwd ? r_fwd_cnt : (r_rd_vld ? r_rd_cnt : '0);
        n_cnt   = cnt_cur;
        wr_en   = 1'b0;
        err     = tcbe_pkg::ERR_NONE;
        n_occ   = r_occ;
        n_fw    = r_fw;
        n_fb    = r_fb;
        fw_sum  = {1'b0, r_fw} + (TW + 1)'(r_n);
        if (r_s1_vld) begin
            case (r_op)
                tcbe_pkg::OP_INSERT: begin
                    if (cnt_cur == {COUNT_BITS{1'b1}}) begin
                        err = tcbe_pkg::ERR_OVERFLOW;
                    end else begin
                        n_cnt        = cnt_cur + COUNT_BITS'(1);
                        wr_en        = 1'b1;
                        n_occ[r_idx] = 1'b1;
                        n_fw         = fw_sum[TW] ? {TW{1'b1}} : fw_sum[TW-1:0];
                        if (r_fb != {TW{1'b1}}) begin
                            n_fb = r_fb + TW'(1);
                        end
                    end
                end
                tcbe_pkg::OP_REMOVE: begin
                    if (cnt_cur == '0) begin
                        err = tcbe_pkg::ERR_EMPTY;
                    end else begin
                        n_cnt = cnt_cur - COUNT_BITS'(1);
                        wr_en = 1'b1;
                        if (n_cnt == '0) begin
                            n_occ[r_idx] = 1'b0;
                        end
                        n_fw = (r_fw > TW'(r_n)) ? r_fw - TW'(r_n) : '0;
                        if (r_fb != '0) begin
                            n_fb = r_fb - TW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // class of the rounded size and the fit search
    tcbe_class_map u_rnd_map (
        .i_n   (r_rounded),
        .o_map (rnd_map)
    );

    tcbe_fit_search #(
        .NCLS (NCLS),
        .IDXW (IDXW)
    ) u_fit (
        .i_occ   (r_occ),
        .i_start ({rnd_map.fl, rnd_map.sl}),
        .o_res   (fit)
    );

    assign in_range = rnd_map.fl < FW'(FL_CLASSES);

    // result fields per opcode
    always_comb begin
        n_found   = 1'b0;
        n_out_fl  = r_fl;
        n_out_sl  = r_sl;
        n_out_rnd = '0;
        case (r_op) inside
            tcbe_pkg::OP_INSERT, tcbe_pkg::OP_REMOVE: begin
                n_out_fl = r_cfl;
                n_out_sl = r_csl;
            end
            tcbe_pkg::OP_SEARCH: begin
                n_out_rnd = r_rounded;
                n_found   = in_range && fit.found;
                n_out_fl  = n_found ? fit.cls[CW-1:SW] : '0;
                n_out_sl  = n_found ? fit.cls[SW-1:0] : '0;
            end
            default: begin
            end
        endcase
    end

    // class state, totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_occ    <= '0;
            r_fw     <= '0;
            r_fb     <= '0;
            r_done   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[in_idx];
            r_occ    <= n_occ;
            r_fw     <= n_fw;
            r_fb     <= n_fb;
            r_done   <= r_s1_vld;
        end
        r_found   <= n_found;
        r_out_fl  <= n_out_fl;
        r_out_sl  <= n_out_sl;
        r_out_rnd <= n_out_rnd;
        r_err     <= err;
    end

    assign o_done             = r_done;
    assign o_found            = r_found;
    assign o_first_level      = r_out_fl;
    assign o_second_level     = r_out_sl;
    assign o_rounded_words    = r_out_rnd;
    assign o_error_code       = r_err;
    assign o_free_block_total = r_fb;
    assign o_free_word_total  = r_fw;

endmodule
